FILE: rtl/core/flv_avc_nal_extractor_top_macros.svh
// Assertion macros shared by the extractor RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FLV_AVC_NAL_EXTRACTOR_TOP_MACROS_SVH
`define FLV_AVC_NAL_EXTRACTOR_TOP_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define FLVNAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Trigger at one edge implies a condition at the next edge.
`define FLVNAL_ASSERT_NEXT(lbl, trig, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (nxt)) \
    else $error(msg);

`endif

FILE: rtl/core/flvnal_pkg.sv
// Shared types for the FLV AVC NAL extractor.
// No dependencies.
package flvnal_pkg;

  // One work record passed from the parser to the expander.
  // sc:   emit a 00 00 00 01 start code first
  // data: emit the byte b (after the start code if sc is set)
  // last/trunc apply to the final beat of the record.
  typedef struct packed {
    logic       sc;
    logic       data;
    logic [7:0] b;
    logic       last;
    logic       trunc;
  } op_t;

endpackage

FILE: rtl/core/flvnal_parser.sv
// Front end: walks the FLV tag header and length prefixes, one byte a beat,
// and turns each accepted byte into at most one work record. Uses flvnal_pkg.
`include "flv_avc_nal_extractor_top_macros.svh"
module flvnal_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_first_i,
  input  logic [23:0]        in_buffer_length_i,
  input  logic [7:0]         video_tag_type_i,
  output logic               op_valid_o,
  output flvnal_pkg::op_t    op_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEAD   = 3'd1;
  localparam logic [2:0] PH_PFX0   = 3'd2;
  localparam logic [2:0] PH_PFX1   = 3'd3;
  localparam logic [2:0] PH_PFX2   = 3'd4;
  localparam logic [2:0] PH_PFX3   = 3'd5;
  localparam logic [2:0] PH_NALHDR = 3'd6;
  localparam logic [2:0] PH_BODY   = 3'd7;

  localparam logic [7:0] NAL_SEI = 8'd6;
  localparam logic [7:0] NAL_AUD = 8'd9;
  localparam logic [7:0] PKT_NALU = 8'h01;
  localparam logic [23:0] POS_FRAME = 24'd11;
  localparam logic [23:0] POS_PKT   = 24'd12;
  localparam logic [23:0] POS_HEND  = 24'd15;

  logic [2:0]  phase_r, phase_nxt;
  logic [23:0] pos_r, pos_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] size_r, size_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic        skip_r, skip_nxt;

  // state as seen by this byte (a first byte restarts everything)
  logic [2:0]  ph;
  logic [23:0] q, len, nsz, rem;
  logic        skp;
  logic        lastbyte, more_pfx, skip_hdr;
  logic [23:0] rem_dec, size_dec;
  logic        emit;
  flvnal_pkg::op_t op;

  assign ph  = in_first_i ? PH_HEAD : phase_r;
  assign q   = in_first_i ? '0 : pos_r;
  assign len = in_first_i ? in_buffer_length_i : len_r;
  assign nsz = in_first_i ? '0 : size_r;
  assign rem = in_first_i ? '0 : rem_r;
  assign skp = in_first_i ? 1'b0 : skip_r;

  assign lastbyte = (({1'b0, q} + 25'd1) == {1'b0, len});
  assign more_pfx = (({1'b0, q} + 25'd5) < {1'b0, len});
  assign skip_hdr = (in_byte_i == NAL_SEI) || (in_byte_i == NAL_AUD);
  assign rem_dec  = (rem != '0) ? rem - 24'd1 : rem;
  assign size_dec = nsz - 24'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    size_nxt  = size_r;
    rem_nxt   = rem_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    op        = '0;
    op.b      = in_byte_i;
    if (accept_i) begin
      phase_nxt = ph;
      pos_nxt   = q;
      len_nxt   = len;
      size_nxt  = nsz;
      rem_nxt   = rem;
      skip_nxt  = skp;
      if (ph == PH_IDLE) begin
        phase_nxt = PH_IDLE;
      end else if (q >= len) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (ph)
          PH_HEAD: begin
            if (q == '0 && in_byte_i != video_tag_type_i) begin
              phase_nxt = PH_IDLE;
            end else if (q == POS_FRAME && in_byte_i[7:4] != 4'd1 &&
                         in_byte_i[7:4] != 4'd2) begin
              phase_nxt = PH_IDLE;
            end else if (q == POS_PKT && in_byte_i != PKT_NALU) begin
              phase_nxt = PH_IDLE;
            end else if (q == POS_HEND) begin
              phase_nxt = PH_PFX0;
            end
          end
          PH_PFX0: begin
            phase_nxt = more_pfx ? PH_PFX1 : PH_IDLE;
          end
          PH_PFX1: begin
            size_nxt  = {in_byte_i, 16'h0000};
            phase_nxt = PH_PFX2;
          end
          PH_PFX2: begin
            size_nxt  = nsz | {8'h00, in_byte_i, 8'h00};
            phase_nxt = PH_PFX3;
          end
          PH_PFX3: begin
            size_nxt  = nsz | {16'h0000, in_byte_i};
            phase_nxt = PH_NALHDR;
          end
          PH_NALHDR: begin
            if (nsz == '0) begin
              // empty NAL: start code only, its 01 closes the unit
              emit      = !skip_hdr;
              op.sc     = 1'b1;
              op.last   = 1'b1;
              phase_nxt = more_pfx ? PH_PFX1 : PH_IDLE;
            end else begin
              rem_nxt   = size_dec;
              skip_nxt  = skip_hdr;
              emit      = !skip_hdr;
              op.sc     = 1'b1;
              op.data   = 1'b1;
              op.last   = (size_dec == '0) || lastbyte;
              op.trunc  = (size_dec != '0) && lastbyte;
              phase_nxt = (size_dec == '0) ? PH_PFX0 : PH_BODY;
            end
          end
          PH_BODY: begin
            rem_nxt   = rem_dec;
            emit      = !skp;
            op.data   = 1'b1;
            op.last   = (rem_dec == '0) || lastbyte;
            op.trunc  = (rem_dec != '0) && lastbyte;
            if (rem_dec == '0) phase_nxt = PH_PFX0;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
        pos_nxt = q + 24'd1;
        if (lastbyte) phase_nxt = PH_IDLE;
      end
    end
  end

  assign op_valid_o = emit;
  assign op_o       = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      size_r  <= '0;
      rem_r   <= '0;
      skip_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      size_r  <= size_nxt;
      rem_r   <= rem_nxt;
      skip_r  <= skip_nxt;
    end
  end

  `FLVNAL_ASSERT(a_trunc_has_last, !(op_valid_o && op_o.trunc && !op_o.last),
                 "truncated record without last")
  `FLVNAL_ASSERT(a_body_has_rem, !(phase_r == PH_BODY && rem_r == '0),
                 "body phase with nothing remaining")

endmodule

FILE: rtl/core/flvnal_opq.sv
// Short record queue between parser and expander.
// Uses flvnal_pkg::op_t; first-word-fall-through on the read side.
`include "flv_avc_nal_extractor_top_macros.svh"
module flvnal_opq #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  flvnal_pkg::op_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output flvnal_pkg::op_t rdata_o,
  output logic            empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flvnal_pkg::op_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata_i;
  end

  `FLVNAL_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count overflow")
  `FLVNAL_ASSERT_NEXT(a_push_counts, do_push && !do_pop,
                      count_r == $past(count_r) + CW'(1), "push not counted")

endmodule

FILE: rtl/core/flvnal_expander.sv
// Back end: expands each queued record into output beats (start code bytes
// and payload byte) and holds them in the output register. Uses flvnal_pkg.
`include "flv_avc_nal_extractor_top_macros.svh"
module flvnal_expander (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty_i,
  input  flvnal_pkg::op_t q_rdata_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            out_nal_last,
  output logic            out_nal_truncated
);

  // beat index: 0..2 zero bytes, 3 the 01 byte, 4 the payload byte
  localparam logic [2:0] BEAT_ONE  = 3'd3;
  localparam logic [2:0] BEAT_DATA = 3'd4;
  localparam logic [7:0] SC_ZERO   = 8'h00;
  localparam logic [7:0] SC_ONE    = 8'h01;

  flvnal_pkg::op_t cur_r, cur_nxt;
  logic            have_r, have_nxt;
  logic [2:0]      beat_r, beat_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r;
  logic            ol_r, ot_r;

  logic       slot_free, take, final_beat;
  logic [7:0] bb;
  logic       bl, bt;

  assign slot_free  = !ov_r || pop;
  assign take       = have_r && slot_free;
  assign final_beat = (beat_r == BEAT_DATA) || (beat_r == BEAT_ONE && !cur_r.data);
  assign q_pop_o    = !q_empty_i && (!have_r || (take && final_beat));

  always_comb begin
    bb = SC_ZERO;
    bl = 1'b0;
    bt = 1'b0;
    if (beat_r == BEAT_DATA) begin
      bb = cur_r.b;
      bl = cur_r.last;
      bt = cur_r.trunc;
    end else if (beat_r == BEAT_ONE) begin
      bb = SC_ONE;
      bl = cur_r.last && !cur_r.data;
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    have_nxt = have_r;
    beat_nxt = beat_r;
    if (take) begin
      beat_nxt = beat_r + 3'd1;
      if (final_beat) have_nxt = 1'b0;
    end
    if (q_pop_o) begin
      cur_nxt  = q_rdata_i;
      have_nxt = 1'b1;
      beat_nxt = q_rdata_i.sc ? 3'd0 : BEAT_DATA;
    end
    ov_nxt = ov_r;
    if (take) ov_nxt = 1'b1;
    else if (pop) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      beat_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      have_r <= have_nxt;
      beat_r <= beat_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (take) begin
      ob_r <= bb;
      ol_r <= bl;
      ot_r <= bt;
    end
  end

  assign empty             = !ov_r;
  assign out_byte          = ob_r;
  assign out_nal_last      = ol_r;
  assign out_nal_truncated = ot_r;

  `FLVNAL_ASSERT(a_beat_range, !have_r || beat_r <= BEAT_DATA, "beat index out of range")
  `FLVNAL_ASSERT(a_plain_data, !(have_r && !cur_r.sc && beat_r != BEAT_DATA),
                 "plain record not on payload beat")

endmodule

FILE: rtl/core/flv_avc_nal_extractor_top.sv
// Top level of the FLV AVC NAL extractor: APB register, parser, record
// queue and expander. Uses flvnal_pkg, flvnal_parser, flvnal_opq, flvnal_expander.
//
// Usage:
//  - Input channel (push/full): one beat per tag byte, starting at the tag
//    type byte. in_first marks byte zero and carries in_buffer_length.
//    A beat is taken whenever push is high and full is low, one per cycle.
//  - Result channel (empty/pop): Annex B bytes, start codes included, with
//    out_nal_last on the final byte of each NAL and out_nal_truncated when
//    the buffer ended early. The beat on the ports is taken on pop & !empty.
//  - Register 0 at address 0 (APB, pready tied high): video tag type,
//    reset 9. Write only while the block is idle.
//  - Path: a byte that produces output passes the queue write, the expander
//    load and the output register, in that order, before its first beat shows.
//  - Throughput: input one byte per cycle unless full; output one beat per
//    cycle while pop is high. A NAL header byte makes five beats (start code
//    plus itself), so the output port sets the sustained rate; the QUEUE_DEPTH
//    record queue soaks up start code bursts, and full rises when it fills.
//  - Receiver stall: the output register holds its beat, the expander
//    stops, the queue fills, then full stops the input.
//  - Reset (rst_n low, synchronous): parser idle, queue and output empty,
//    register back to 9; bytes before the first in_first are dropped.
module flv_avc_nal_extractor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  input  logic [23:0] in_buffer_length,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_nal_last,
  output logic        out_nal_truncated,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic       REG_TAG_TYPE = 1'b0;  // word index of the only register
  localparam logic [7:0] TAG_VIDEO    = 8'd9;

  logic [7:0] tag_type_r;
  logic       cfg_wr;

  logic            accept;
  logic            op_valid;
  flvnal_pkg::op_t op;
  logic            q_full, q_empty, q_pop;
  flvnal_pkg::op_t q_rdata;

  // ---- configuration register ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TAG_TYPE);
  assign prdata = (paddr[2] == REG_TAG_TYPE) ? {24'h000000, tag_type_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_type_r <= TAG_VIDEO;
    end else if (cfg_wr) begin
      tag_type_r <= pwdata[7:0];
    end
  end

  // ---- front: byte accepted only when the queue can take its record ----
  assign full   = q_full;
  assign accept = push && !q_full;

  flvnal_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept_i           (accept),
    .in_byte_i          (in_byte),
    .in_first_i         (in_first),
    .in_buffer_length_i (in_buffer_length),
    .video_tag_type_i   (tag_type_r),
    .op_valid_o         (op_valid),
    .op_o               (op)
  );

  // ---- queue between front and back ----
  flvnal_opq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (op_valid),
    .wdata_i (op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // ---- back: start code insertion and output register ----
  flvnal_expander u_expander (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty_i         (q_empty),
    .q_rdata_i         (q_rdata),
    .q_pop_o           (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_nal_last      (out_nal_last),
    .out_nal_truncated (out_nal_truncated)
  );

endmodule
